/* rtl/ita_pkg.sv */
// Shared types, constants and helpers for the integer to ASCII formatter.
`timescale 1ns / 1ps
package ita_pkg;

  // Operation codes carried with each number.
  typedef enum logic [1:0] {
    OpSignedDec   = 2'd0,
    OpUnsignedDec = 2'd1,
    OpHex         = 2'd2
  } ita_op_e;

  localparam int HexDigits  = 16;
  localparam int MaxDigits  = 16;
  localparam int CntW       = $clog2(MaxDigits + 1);
  localparam int DigIdxW    = $clog2(MaxDigits);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0]  ChZero    = 8'h30;
  localparam logic [7:0]  ChLetterA = 8'h61;
  localparam logic [7:0]  ChMinus   = 8'h2d;
  localparam logic [3:0]  DecBase   = 4'd10;
  // Reciprocal of ten, scaled by two to the 35th.
  localparam logic [31:0] RecipTen  = 32'hcccc_cccd;

  // One classified number waiting for conversion.
  typedef struct packed {
    logic        hex;
    logic        neg;
    logic [63:0] value;
  } ita_entry_t;

  typedef struct packed {
    logic       valid;
    ita_entry_t entry;
  } ita_push_t;

  typedef struct packed {
    logic       valid;
    ita_entry_t entry;
  } ita_head_t;

  function automatic logic [7:0] ita_char(logic [3:0] dig);
    logic [7:0] ch;
    if (dig < DecBase) begin
      ch = ChZero + {4'd0, dig};
    end else begin
      ch = ChLetterA + {4'd0, dig - DecBase};
    end
    return ch;
  endfunction

endpackage

/* rtl/ita_if.sv */
// Valid/ready channel interfaces for numbers in and characters out.
`timescale 1ns / 1ps
interface ita_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] number;

  modport source (output valid, output operation, output number, input ready);
  modport sink (input valid, input operation, input number, output ready);
endinterface

interface ita_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

/* rtl/integer_to_ascii_formatter.sv */
// Top level of the integer to ASCII text formatter.
//
// Usage: numbers enter on in_i with an operation code (signed decimal and
// unsigned decimal of the low 32 bits, or lower-case hex of all 64 bits);
// characters leave on out_o, most significant digit first, with last set on
// the final beat of each number. An unused operation code is taken and dropped.
// The front end queues up to two numbers. The converter takes a number from
// the queue, then writes one digit per step: for hex it shifts out a nibble,
// for decimal it does a 32 by 32 reciprocal multiply, then the quotient and
// remainder step. It then sends one character per beat, sign included, and
// finishes a number's text before it takes the next from the queue. Once the
// digits are complete, the sign or emit state loads the output register.
// Reset clears the queue, the converter state and the output valid flag.
// When the receiver stalls, the output register holds its beat, the converter
// waits, and the queue fills until in_i.ready drops.
`timescale 1ns / 1ps
module integer_to_ascii_formatter import ita_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ita_in_if.sink    in_i,
  ita_out_if.source out_o
);

  ita_push_t push;
  ita_head_t head;
  logic      full;
  logic      pop;

  ita_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  ita_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  ita_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni) push.valid |-> !full
  ) else $error("queue written while full");

  a_pop_needs_entry: assert property (
    @(posedge clk_i) disable iff (!rst_ni) pop |-> head.valid
  ) else $error("converter took an entry from an empty queue");

  a_unused_op_dropped: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !(in_i.operation == OpSignedDec ||
     in_i.operation == OpUnsignedDec || in_i.operation == OpHex)) |-> !push.valid
  ) else $error("unused operation code reached the queue");

  a_pop_clears_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (full && pop) |=> !full
  ) else $error("queue stayed full after a pop with no room for a push");
`endif

endmodule

/* rtl/ita_front.sv */
// Front end: accepts numbers, picks the operand and sign, and queues them.
`timescale 1ns / 1ps
module ita_front import ita_pkg::*; (
  ita_in_if.sink    in_i,
  input  logic      full_i,
  output ita_push_t push_o
);

  logic [31:0] low_w;

  assign low_w     = in_i.number[31:0];
  assign in_i.ready = !full_i;

  always_comb begin
    push_o.valid       = 1'b0;
    push_o.entry.hex   = 1'b0;
    push_o.entry.neg   = 1'b0;
    push_o.entry.value = {32'd0, low_w};
    unique case (in_i.operation)
      OpSignedDec: begin
        push_o.valid = in_i.valid && !full_i;
        // The magnitude is taken as unsigned, so the most negative value fits.
        if (low_w[31]) begin
          push_o.entry.neg   = 1'b1;
          push_o.entry.value = {32'd0, 32'd0 - low_w};
        end
      end
      OpUnsignedDec: begin
        push_o.valid = in_i.valid && !full_i;
      end
      OpHex: begin
        push_o.valid       = in_i.valid && !full_i;
        push_o.entry.hex   = 1'b1;
        push_o.entry.value = in_i.number;
      end
      default: begin
        // An unused code is taken and dropped without output.
        push_o.valid = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/ita_fifo.sv */
// Short queue between the front end and the converter.
`timescale 1ns / 1ps
module ita_fifo import ita_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ita_push_t push_i,
  input  logic      pop_i,
  output logic      full_o,
  output ita_head_t head_o
);

  ita_entry_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]       cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o       = (cnt_q == QCntW'(QueueDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

/* rtl/ita_back.sv */
// Converter: splits the value into digits, then sends the text one beat at a time.
`timescale 1ns / 1ps
module ita_back import ita_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ita_head_t head_i,
  output logic      pop_o,
  ita_out_if.source out_o
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMul  = 6'b000010,
    StDiv  = 6'b000100,
    StHex  = 6'b001000,
    StSign = 6'b010000,
    StEmit = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [63:0]       val_q, val_d;
  logic [63:0]       prod_q, prod_d;
  logic              neg_q, neg_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   cnt_m1;
  logic [3:0]        dig_q [MaxDigits];
  logic              dig_we;
  logic [3:0]        dig_wdata;
  logic [28:0]       quot;
  logic [31:0]       rem;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_char_q, out_char_d;
  logic              out_last_q, out_last_d;
  logic              out_free;

  assign out_free        = !out_valid_q || out_o.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last      = out_last_q;
  assign cnt_m1          = cnt_q - 1'b1;

  // Quotient by ten from the registered reciprocal product.
  assign quot = prod_q[63:35];
  assign rem  = val_q[31:0] - ({quot, 3'd0} + {2'd0, quot, 1'b0});

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    pop_o       = 1'b0;
    dig_we      = 1'b0;
    dig_wdata   = val_q[3:0];
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      StIdle: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          val_d   = head_i.entry.value;
          neg_d   = head_i.entry.neg;
          cnt_d   = '0;
          state_d = head_i.entry.hex ? StHex : StMul;
        end
      end
      StMul: begin
        prod_d  = {32'd0, val_q[31:0]} * {32'd0, RecipTen};
        state_d = StDiv;
      end
      StDiv: begin
        dig_we    = 1'b1;
        dig_wdata = rem[3:0];
        val_d     = {35'd0, quot};
        cnt_d     = cnt_q + 1'b1;
        if (quot == '0) begin
          state_d = neg_q ? StSign : StEmit;
        end else begin
          state_d = StMul;
        end
      end
      StHex: begin
        dig_we    = 1'b1;
        dig_wdata = val_q[3:0];
        val_d     = {4'd0, val_q[63:4]};
        cnt_d     = cnt_q + 1'b1;
        if ((val_q[63:4] == '0) || (cnt_q + 1'b1 == CntW'(HexDigits))) begin
          state_d = StEmit;
        end
      end
      StSign: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = ChMinus;
          out_last_d  = 1'b0;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = ita_char(dig_q[cnt_m1[DigIdxW-1:0]]);
          out_last_d  = (cnt_q == CntW'(1));
          cnt_d       = cnt_m1;
          if (cnt_q == CntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    prod_q     <= prod_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (dig_we) begin
      dig_q[cnt_q[DigIdxW-1:0]] <= dig_wdata;
    end
  end

endmodule

/* test/testbench.sv */
// Self-checking testbench for the integer to ASCII text formatter.
`timescale 1ns / 1ps
module testbench;
  import ita_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int RandomNumbers = 390;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] number;
  } number_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ita_in_if  in_if ();
  ita_out_if out_if ();

  integer_to_ascii_formatter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  number_item_t pending_numbers_q[$];
  text_beat_t   expected_text_q[$];
  int           numbers_total = 0;
  int           numbers_taken = 0;
  int           fail_count = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_mode = 0;
  int           stall_cycles = 0;
  logic         hold_off = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Expected text of one number, most significant character first.
  function automatic void format_number_text(input logic [1:0] op, input logic [63:0] num);
    logic [63:0] mag;
    logic [63:0] base;
    logic [7:0]  rem;
    logic [7:0]  digits[MaxDigits];
    logic        minus;
    int          limit;
    int          n;
    minus = 1'b0;
    n = 0;
    case (op)
      OpSignedDec: begin
        mag = {32'd0, num[31:0]};
        // The magnitude stays unsigned, so the most negative value is exact.
        if (num[31]) begin
          minus = 1'b1;
          mag = {32'd0, 32'd0 - num[31:0]};
        end
        base = 64'd10;
        limit = 10;
      end
      OpUnsignedDec: begin
        mag = {32'd0, num[31:0]};
        base = 64'd10;
        limit = 10;
      end
      OpHex: begin
        mag = num;
        base = 64'd16;
        limit = HexDigits < 1 ? 1 : (HexDigits > MaxDigits ? MaxDigits : HexDigits);
      end
      default: return;
    endcase
    do begin
      rem = 8'(mag % base);
      digits[n] = rem < 8'd10 ? ChZero + rem : ChLetterA + rem - 8'd10;
      n++;
      mag = mag / base;
    end while (mag != 64'd0 && n < limit);
    if (minus) expected_text_q.push_back('{character: ChMinus, last: 1'b0});
    for (int i = n - 1; i >= 0; i--) begin
      expected_text_q.push_back('{character: digits[i], last: (i == 0)});
    end
  endfunction

  function automatic void queue_number(input logic [1:0] op, input logic [63:0] num);
    pending_numbers_q.push_back('{operation: op, number: num});
    numbers_total++;
  endfunction

  // Full-width, random-length, small values and low words near 2^32-1 or 2^31.
  function automatic logic [63:0] random_number();
    logic [63:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return full;
      1: return full >> $urandom_range(0, 63);
      2: return 64'($urandom_range(0, 20));
      3: return {full[63:32], 32'hffff_ffff - 32'($urandom_range(0, 3))};
      default: return {full[63:32], 32'h8000_0000 + 32'($urandom_range(0, 2))};
    endcase
  endfunction

  initial begin
    in_if.valid = 1'b0;
    in_if.operation = OpSignedDec;
    in_if.number = 64'd0;
    out_if.ready = 1'b0;
  end

  // Driver: bursts of beats with random gaps, holding each beat until taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        format_number_text(in_if.operation, in_if.number);
        numbers_taken++;
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_numbers_q.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.operation <= pending_numbers_q[0].operation;
          in_if.number <= pending_numbers_q[0].number;
          pending_numbers_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each character beat and stalls on a changing pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_text_q.size() == 0) begin
          $error("unexpected character beat: character %h last %b",
                 out_if.character, out_if.last);
          fail_count++;
        end else begin
          if (out_if.character !== expected_text_q[0].character) begin
            $error("character: expected %h, got %h",
                   expected_text_q[0].character, out_if.character);
            fail_count++;
          end
          if (out_if.last !== expected_text_q[0].last) begin
            $error("last: expected %b, got %b", expected_text_q[0].last, out_if.last);
            fail_count++;
          end
          expected_text_q.pop_front();
        end
      end
      if (stall_cycles == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_cycles = $urandom_range(16, 96);
      end else begin
        stall_cycles--;
      end
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 1) == 1);
          default: out_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Long receiver hold-off while numbers keep arriving, so the input stalls.
  initial begin
    wait (numbers_taken >= 60);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("integer_to_ascii_formatter regression: fail");
    $finish;
  end

  initial begin
    int guard;
    logic [1:0] op;
    // Directed: zero, extremes, sign boundary, ignored upper bits and unused ops.
    queue_number(OpSignedDec, 64'd0);
    queue_number(OpSignedDec, 64'd7);
    queue_number(OpSignedDec, 64'h0000_0000_ffff_ffff);
    queue_number(OpSignedDec, 64'h0000_0000_8000_0000);
    queue_number(OpSignedDec, 64'h0000_0000_7fff_ffff);
    queue_number(OpSignedDec, 64'hffff_ffff_0000_0005);
    queue_number(OpSignedDec, 64'h1234_5678_ffff_fff6);
    queue_number(OpUnsignedDec, 64'd0);
    queue_number(OpUnsignedDec, 64'h0000_0000_ffff_ffff);
    queue_number(OpUnsignedDec, 64'hffff_ffff_ffff_ffff);
    queue_number(OpUnsignedDec, 64'd1_000_000_000);
    queue_number(OpUnsignedDec, 64'h0000_0000_8000_0000);
    queue_number(OpHex, 64'd0);
    queue_number(OpHex, 64'hffff_ffff_ffff_ffff);
    queue_number(OpHex, 64'h8000_0000_0000_0000);
    queue_number(OpHex, 64'hf);
    queue_number(OpHex, 64'h10);
    queue_number(OpHex, 64'h0123_4567_89ab_cdef);
    queue_number(OpHex, 64'hfedc_ba98_7654_3210);
    queue_number(OpHex, 64'h0000_0000_ffff_ffff);
    queue_number(OpUnused, 64'd0);
    queue_number(OpUnused, 64'hffff_ffff_ffff_ffff);
    queue_number(OpSignedDec, 64'd9);
    for (int i = 0; i < RandomNumbers; i++) begin
      op = ($urandom_range(0, 19) == 0) ? OpUnused : 2'($urandom_range(0, 2));
      queue_number(op, random_number());
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (numbers_taken == numbers_total);
    guard = 0;
    while (expected_text_q.size() != 0 && guard < 100_000) begin
      @(posedge clk_i);
      guard++;
    end
    // The last number may be an ignored code, so give the converter time to drain.
    repeat (100) @(posedge clk_i);
    if (expected_text_q.size() != 0) begin
      $error("%0d expected characters never arrived", expected_text_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("integer_to_ascii_formatter regression: pass");
    end else begin
      $display("integer_to_ascii_formatter regression: fail");
    end
    $finish;
  end

endmodule
